// ----- rtl/core/hed_pkg.sv -----
// Shared types, constants and the named character reference table of the entity decoder.
package hed_pkg;

    localparam int unsigned NAME_COUNT = 39;
    localparam int unsigned NAME_CHARS = 6;
    localparam int unsigned CP_W       = 21;
    localparam int unsigned NAME_IDX_W = $clog2(NAME_COUNT);

    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_REPLACE = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_LIM1    = 21'h000080;
    localparam logic [CP_W-1:0] CP_LIM2    = 21'h000800;
    localparam logic [CP_W-1:0] CP_LIM3    = 21'h010000;

    // One finished candidate, handed from the parser to the encoder.
    typedef struct packed {
        logic            ok;
        logic [CP_W-1:0] cp;
    } hed_rec_t;

    // Names are right-justified: the last character sits in the low byte.
    localparam logic [8*NAME_CHARS-1:0] NAME_TXT [0:NAME_COUNT-1] = '{
        "AMP",    "COPY",   "GT",     "LT",     "QUOT",   "REG",
        "amp",    "apos",   "bull",   "copy",   "dagger", "deg",
        "ge",     "gt",     "harr",   "hellip", "infin",  "laquo",
        "larr",   "ldquo",  "le",     "lsquo",  "lt",     "mdash",
        "middot", "nbsp",   "ndash",  "ne",     "para",   "plusmn",
        "quot",   "raquo",  "rarr",   "rdquo",  "reg",    "rsquo",
        "sect",   "times",  "trade"
    };

    localparam logic [2:0] NAME_LEN [0:NAME_COUNT-1] = '{
        3'd3, 3'd4, 3'd2, 3'd2, 3'd4, 3'd3,
        3'd3, 3'd4, 3'd4, 3'd4, 3'd6, 3'd3,
        3'd2, 3'd2, 3'd4, 3'd6, 3'd5, 3'd5,
        3'd4, 3'd5, 3'd2, 3'd5, 3'd2, 3'd5,
        3'd6, 3'd4, 3'd5, 3'd2, 3'd4, 3'd6,
        3'd4, 3'd5, 3'd4, 3'd5, 3'd3, 3'd5,
        3'd4, 3'd5, 3'd5
    };

    localparam logic [CP_W-1:0] NAME_CP [0:NAME_COUNT-1] = '{
        21'd38,   21'd169,  21'd62,   21'd60,   21'd34,   21'd174,
        21'd38,   21'd39,   21'd8226, 21'd169,  21'd8224, 21'd176,
        21'd8805, 21'd62,   21'd8596, 21'd8230, 21'd8734, 21'd171,
        21'd8592, 21'd8220, 21'd8804, 21'd8216, 21'd60,   21'd8212,
        21'd183,  21'd160,  21'd8211, 21'd8800, 21'd182,  21'd177,
        21'd34,   21'd187,  21'd8594, 21'd8221, 21'd174,  21'd8217,
        21'd167,  21'd215,  21'd8482
    };

    // Character at position p of name idx; only meaningful for p below the name length.
    function automatic logic [7:0] name_char(input logic [NAME_IDX_W-1:0] idx,
                                             input logic [2:0] p);
        logic [2:0] sel;
        sel = NAME_LEN[idx] - p - 3'd1;
        return NAME_TXT[idx][{sel, 3'b000} +: 8];
    endfunction

endpackage

// ----- rtl/core/hed_front.sv -----
// Byte parser: classifies each candidate byte and emits one record per candidate.
module hed_front
    import hed_pkg::*;
#(
    parameter int unsigned NAME_LIMIT = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        is_last,
    input  logic        q_full,
    output logic        push,
    output hed_rec_t    push_rec
);

    localparam int unsigned PW = $clog2(NAME_LIMIT + 1);

    localparam logic [2:0] MODE_AMP   = 3'd0;
    localparam logic [2:0] MODE_BODY0 = 3'd1;
    localparam logic [2:0] MODE_HASH  = 3'd2;
    localparam logic [2:0] MODE_DEC   = 3'd3;
    localparam logic [2:0] MODE_HEX   = 3'd4;
    localparam logic [2:0] MODE_NAME  = 3'd5;
    localparam logic [2:0] MODE_FAIL  = 3'd6;

    localparam logic [NAME_COUNT-1:0] MASK_ALL = {NAME_COUNT{1'b1}};

    logic [2:0]            mode_reg, mode_next;
    logic [PW-1:0]         pos_reg, pos_next;
    logic [CP_W-1:0]       acc_reg, acc_next;
    logic                  seen_reg, seen_next;
    logic [NAME_COUNT-1:0] mask_reg, mask_next;

    logic                  accept;
    logic [NAME_COUNT-1:0] keep;
    logic [NAME_COUNT-1:0] hit;
    logic [CP_W-1:0]       name_cp;
    logic                  is_dec;
    logic                  is_hex;
    logic [3:0]            dig;
    logic [CP_W+3:0]       dec_sum;
    logic [CP_W+3:0]       hex_sum;
    logic                  fin_ok;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Digit classification and the two accumulator candidates.
    always_comb
    begin
        is_dec = in_byte inside {[8'h30:8'h39]};
        is_hex = 1'b1;
        dig    = 4'd0;
        if (is_dec)
        begin
            dig = in_byte[3:0];
        end
        else if (in_byte inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            dig = in_byte[3:0] + 4'd9;
        end
        else
        begin
            is_hex = 1'b0;
        end
        dec_sum = (CP_W+4)'(acc_reg) * (CP_W+4)'(10) + (CP_W+4)'(dig);
        hex_sum = {acc_reg, dig};
    end

    // Parallel compare against every table name at the current position.
    always_comb
    begin
        for (int i = 0; i < NAME_COUNT; i++)
        begin
            keep[i] = (pos_reg < PW'(NAME_LEN[i])) && (in_byte != 8'h00)
                      && (name_char(NAME_IDX_W'(i), pos_reg[2:0]) == in_byte);
            hit[i]  = mask_reg[i] && (PW'(NAME_LEN[i]) == pos_reg);
        end
        name_cp = '0;
        for (int i = 0; i < NAME_COUNT; i++)
        begin
            if (hit[i])
            begin
                name_cp = name_cp | NAME_CP[i];
            end
        end
    end

    always_comb
    begin
        fin_ok = 1'b0;
        if (in_byte == 8'h3B)
        begin
            case (mode_reg)
                MODE_DEC:  fin_ok = 1'b1;
                MODE_HEX:  fin_ok = seen_reg;
                MODE_NAME: fin_ok = (pos_reg < PW'(NAME_LIMIT)) && (|hit);
                default:   fin_ok = 1'b0;
            endcase
        end
        push        = accept && is_last;
        push_rec.ok = fin_ok;
        push_rec.cp = (mode_reg == MODE_NAME) ? name_cp : acc_reg;
    end

    // Next state for a non-final byte; the final byte returns everything to reset.
    always_comb
    begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        acc_next  = acc_reg;
        seen_next = seen_reg;
        mask_next = mask_reg;
        if (accept)
        begin
            if (is_last)
            begin
                mode_next = MODE_AMP;
                pos_next  = '0;
                acc_next  = '0;
                seen_next = 1'b0;
                mask_next = MASK_ALL;
            end
            else
            begin
                if (mode_reg != MODE_AMP && pos_reg < PW'(NAME_LIMIT))
                begin
                    pos_next = pos_reg + PW'(1);
                end
                case (mode_reg)
                    MODE_AMP:
                    begin
                        mode_next = (in_byte == 8'h26) ? MODE_BODY0 : MODE_FAIL;
                    end
                    MODE_BODY0:
                    begin
                        if (in_byte == 8'h23)
                        begin
                            mode_next = MODE_HASH;
                        end
                        else
                        begin
                            mode_next = MODE_NAME;
                            mask_next = mask_reg & keep;
                        end
                    end
                    MODE_HASH:
                    begin
                        if (in_byte == 8'h78 || in_byte == 8'h58)
                        begin
                            mode_next = MODE_HEX;
                        end
                        else if (is_dec)
                        begin
                            mode_next = MODE_DEC;
                            acc_next  = CP_W'(dig);
                        end
                        else
                        begin
                            mode_next = MODE_FAIL;
                        end
                    end
                    MODE_DEC:
                    begin
                        if (is_dec && dec_sum <= (CP_W+4)'(CP_MAX))
                        begin
                            acc_next = dec_sum[CP_W-1:0];
                        end
                        else
                        begin
                            mode_next = MODE_FAIL;
                        end
                    end
                    MODE_HEX:
                    begin
                        if (is_hex)
                        begin
                            seen_next = 1'b1;
                        end
                        if (is_hex && hex_sum <= (CP_W+4)'(CP_MAX))
                        begin
                            acc_next = hex_sum[CP_W-1:0];
                        end
                        else
                        begin
                            mode_next = MODE_FAIL;
                        end
                    end
                    MODE_NAME:
                    begin
                        mask_next = mask_reg & keep;
                    end
                    default:
                    begin
                        mode_next = MODE_FAIL;
                    end
                endcase
                if (mode_next == MODE_FAIL)
                begin
                    acc_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_AMP;
            pos_reg  <= '0;
            acc_reg  <= '0;
            seen_reg <= 1'b0;
            mask_reg <= MASK_ALL;
        end
        else
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            acc_reg  <= acc_next;
            seen_reg <= seen_next;
            mask_reg <= mask_next;
        end
    end

endmodule

// ----- rtl/core/hed_queue.sv -----
// Two-entry record queue between the parser and the encoder.
module hed_queue
    import hed_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  hed_rec_t push_rec,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output hed_rec_t head_rec
);

    hed_rec_t   slot_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_rec   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/hed_back.sv -----
// UTF-8 encoder with the registered result stage.
module hed_back
    import hed_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     head_valid,
    input  hed_rec_t head_rec,
    output logic     pop,
    output logic     out_valid,
    input  logic     out_stall,
    output logic [2:0] byte_count,
    output logic [7:0] utf8_b0,
    output logic [7:0] utf8_b1,
    output logic [7:0] utf8_b2,
    output logic [7:0] utf8_b3
);

    logic            valid_reg, valid_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [7:0]      b0_reg, b0_next;
    logic [7:0]      b1_reg, b1_next;
    logic [7:0]      b2_reg, b2_next;
    logic [7:0]      b3_reg, b3_next;
    logic [CP_W-1:0] cp;

    assign pop        = head_valid && (!valid_reg || !out_stall);
    assign out_valid  = valid_reg;
    assign byte_count = cnt_reg;
    assign utf8_b0    = b0_reg;
    assign utf8_b1    = b1_reg;
    assign utf8_b2    = b2_reg;
    assign utf8_b3    = b3_reg;

    always_comb
    begin
        cp       = (head_rec.cp == '0) ? CP_REPLACE : head_rec.cp;
        cnt_next = 3'd0;
        b0_next  = 8'h00;
        b1_next  = 8'h00;
        b2_next  = 8'h00;
        b3_next  = 8'h00;
        if (head_rec.ok)
        begin
            if (cp < CP_LIM1)
            begin
                cnt_next = 3'd1;
                b0_next  = cp[7:0];
            end
            else if (cp < CP_LIM2)
            begin
                cnt_next = 3'd2;
                b0_next  = {3'b110, cp[10:6]};
                b1_next  = {2'b10, cp[5:0]};
            end
            else if (cp < CP_LIM3)
            begin
                cnt_next = 3'd3;
                b0_next  = {4'b1110, cp[15:12]};
                b1_next  = {2'b10, cp[11:6]};
                b2_next  = {2'b10, cp[5:0]};
            end
            else
            begin
                cnt_next = 3'd4;
                b0_next  = {5'b11110, cp[20:18]};
                b1_next  = {2'b10, cp[17:12]};
                b2_next  = {2'b10, cp[11:6]};
                b3_next  = {2'b10, cp[5:0]};
            end
        end
        valid_next = pop || (valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cnt_reg <= cnt_next;
            b0_reg  <= b0_next;
            b1_reg  <= b1_next;
            b2_reg  <= b2_next;
            b3_reg  <= b3_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

// ----- rtl/core/html_entity_to_utf8_decoder.sv -----
// HTML character reference decoder: takes one candidate entity a byte per transaction,
// the final byte flagged by is_last, and returns exactly one result transaction per
// candidate holding a UTF-8 byte count (0 = not decodable, pass the text through) and up
// to four bytes, unused bytes zero. Decimal (&#65;) and hex (&#x41;) forms and 39 fixed
// names are understood; values above 0x10FFFF fail, zero maps to U+FFFD, surrogates are
// encoded as-is. One byte is accepted every cycle while the queue is not full: each byte
// needs a single pass through the parser (a constant multiply-add and a parallel compare
// against all names). A result is written into the queue when its final byte is accepted,
// then moves into the output register, and a two-entry queue plus the output register let
// the input keep flowing while a result waits to be taken.
module html_entity_to_utf8_decoder
    import hed_pkg::*;
#(
    parameter int unsigned NAME_LIMIT = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] byte_count,
    output logic [7:0] utf8_b0,
    output logic [7:0] utf8_b1,
    output logic [7:0] utf8_b2,
    output logic [7:0] utf8_b3
);

    logic     q_full;
    logic     push;
    hed_rec_t push_rec;
    logic     pop;
    logic     head_valid;
    hed_rec_t head_rec;

    // Front: parse bytes, hold per-candidate state, push one record at the final byte.
    hed_front #(
        .NAME_LIMIT (NAME_LIMIT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .is_last  (is_last),
        .q_full   (q_full),
        .push     (push),
        .push_rec (push_rec)
    );

    // Queue: decouple the parser from a stalled output.
    hed_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    // Back: encode the code point and hold it until the transaction completes.
    hed_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .byte_count (byte_count),
        .utf8_b0    (utf8_b0),
        .utf8_b1    (utf8_b1),
        .utf8_b2    (utf8_b2),
        .utf8_b3    (utf8_b3)
    );

endmodule
